// ----- design/assert_macros.svh -----
// Assertion macros shared by the knock control RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KD_ASSERT(lbl, clk, rst_n, prop, msg)
`define KD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- design/kdrc_pkg.sv -----
// Shared types, constants and helper functions of the knock control block.
package kdrc_pkg;

  localparam int CYLINDERS = 8;
  localparam int SENSORS   = 2;
  localparam int RPM_BINS  = 16;

  localparam int CYL_W  = $clog2(CYLINDERS);
  localparam int SEN_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int BIN_W  = $clog2(RPM_BINS);
  localparam int TBL_DEPTH = SENSORS * RPM_BINS;
  localparam int TBL_AW = SEN_W + BIN_W;

  localparam int MODE_W = 3;
  localparam int RAW_W  = 12;
  localparam int RPM_W  = 14;
  localparam int MV_W   = 20;
  localparam int SIG_W  = 24;
  localparam int RET_W  = 16;
  localparam int CNT_W  = 32;
  localparam int MULA_W = 25;
  localparam int MULB_W = 18;
  localparam int PROD_W = MULA_W + MULB_W;
  localparam int ACC_W  = 48;
  localparam int STEP_W = 2;
  localparam logic [STEP_W-1:0] MAC_LAST = 2'd3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_RATIO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_ALPHA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETARD_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RETARD_LIMIT    = 3'd5;

  localparam logic [7:0]  RST_THRESHOLD_RATIO = 8'd40;
  localparam logic [15:0] RST_NOISE_ALPHA     = 16'd3277;
  localparam logic [19:0] RST_NOISE_FLOOR_MIN = 20'd5120;
  localparam logic [15:0] RST_RETARD_STEP     = 16'd512;
  localparam logic [15:0] RST_ADVANCE_STEP    = 16'd26;
  localparam logic [15:0] RST_RETARD_LIMIT    = 16'd2560;
  localparam logic [SIG_W-1:0] NOISE_INIT     = 24'd12800;

  // Bandpass coefficients in Q16, feedback terms already negated.
  localparam logic signed [MULB_W-1:0] COEF_B0  = 18'sd4011;
  localparam logic signed [MULB_W-1:0] COEF_B2  = -18'sd4011;
  localparam logic signed [MULB_W-1:0] COEF_NA1 = 18'sd122579;
  localparam logic signed [MULB_W-1:0] COEF_NA2 = -18'sd57514;

  typedef enum logic [MODE_W-1:0] {
    MODE_OPEN    = 3'd0,
    MODE_CLOSE   = 3'd1,
    MODE_SAMPLE  = 3'd2,
    MODE_PROCESS = 3'd3,
    MODE_NOISE   = 3'd4,
    MODE_FLUSH   = 3'd5,
    MODE_QUERY   = 3'd6,
    MODE_SPARE   = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_SAMPLING = 2'd1,
    PH_PROCESS  = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_SIMPLE, CMD_MV, CMD_MAC, CMD_FILT, CMD_TBL_RD,
    CMD_EV_MUL, CMD_EV_UPD, CMD_EV_DONE, CMD_NS_M1, CMD_NS_M2, CMD_NS_WR,
    CMD_REPORT
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SEN_W-1:0]  sidx;
    logic [STEP_W-1:0] step;
  } ctl_t;

  typedef struct packed {
    mode_t mode;
    logic  sample_ok;
  } sts_t;

  typedef struct packed {
    logic [RET_W-1:0]        cylinder_retard;
    logic                    cylinder_knocked;
    logic [RET_W-1:0]        bank1_retard;
    logic [RET_W-1:0]        bank2_retard;
    logic                    knock_active;
    logic [CNT_W-1:0]        event_total;
    logic signed [SIG_W-1:0] filtered_out;
  } res_t;

  function automatic logic [SEN_W-1:0] sensor_of(input logic [CYL_W-1:0] c);
    int s;
    s = (int'(c) * SENSORS) / CYLINDERS;
    return SEN_W'(s);
  endfunction

  // Bin is rpm/500 clamped to the last bin, found by independent compares.
  function automatic logic [BIN_W-1:0] rpm_bin(input logic [RPM_W-1:0] rpm);
    logic [BIN_W-1:0] b;
    b = '0;
    for (int k = 1; k < RPM_BINS; k++) begin
      if ({18'd0, rpm} >= 32'(k * 500)) b = BIN_W'(k);
    end
    return b;
  endfunction

  function automatic logic [SIG_W-1:0] mag24(input logic signed [SIG_W-1:0] v);
    return v[SIG_W-1] ? SIG_W'(-v) : SIG_W'(v);
  endfunction

endpackage

// ----- design/kdrc_if.sv -----
// Valid/ready channel interfaces for the event word and the result word.
interface kdrc_in_if;
  import kdrc_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CYL_W-1:0]  cylinder;
  logic [SEN_W-1:0]  sensor;
  logic [RAW_W-1:0]  raw_sample;
  logic [RPM_W-1:0]  rpm_value;
  modport source (output valid, mode, cylinder, sensor, raw_sample, rpm_value,
                  input ready);
  modport sink (input valid, mode, cylinder, sensor, raw_sample, rpm_value,
                output ready);
endinterface

interface kdrc_out_if;
  import kdrc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [RET_W-1:0]        cylinder_retard;
  logic                    cylinder_knocked;
  logic [RET_W-1:0]        bank1_retard;
  logic [RET_W-1:0]        bank2_retard;
  logic                    knock_active;
  logic [CNT_W-1:0]        event_total;
  logic signed [SIG_W-1:0] filtered_out;
  modport source (output valid, cylinder_retard, cylinder_knocked, bank1_retard,
                  bank2_retard, knock_active, event_total, filtered_out,
                  input ready);
  modport sink (input valid, cylinder_retard, cylinder_knocked, bank1_retard,
                bank2_retard, knock_active, event_total, filtered_out,
                output ready);
endinterface

// ----- design/kdrc_ctrl.sv -----
// Sequencing state machine of the knock control block.
`include "assert_macros.svh"
module kdrc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  kdrc_pkg::sts_t  sts,
  output kdrc_pkg::ctl_t  ctl
);
  import kdrc_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_DISP    = 14'b00000000000010,
    S_MV      = 14'b00000000000100,
    S_MAC     = 14'b00000000001000,
    S_FILT    = 14'b00000000010000,
    S_EV_RD   = 14'b00000000100000,
    S_EV_MUL  = 14'b00000001000000,
    S_EV_UPD  = 14'b00000010000000,
    S_EV_DONE = 14'b00000100000000,
    S_NS_RD   = 14'b00001000000000,
    S_NS_M1   = 14'b00010000000000,
    S_NS_M2   = 14'b00100000000000,
    S_NS_WR   = 14'b01000000000000,
    S_REPORT  = 14'b10000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SEN_W-1:0]  sidx_r, sidx_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              last_sen;

  assign last_sen  = (sidx_r == SEN_W'(SENSORS - 1));
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    sidx_nxt      = sidx_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    ctl.cmd       = CMD_NONE;
    ctl.sidx      = sidx_r;
    ctl.step      = step_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cmd   = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        ctl.cmd  = CMD_SIMPLE;
        sidx_nxt = '0;
        step_nxt = '0;
        case (sts.mode)
          MODE_SAMPLE:  state_nxt = sts.sample_ok ? S_MV : S_REPORT;
          MODE_PROCESS: state_nxt = S_EV_RD;
          MODE_NOISE:   state_nxt = S_NS_RD;
          default:      state_nxt = S_REPORT;
        endcase
      end
      S_MV: begin
        ctl.cmd   = CMD_MV;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        ctl.cmd  = CMD_MAC;
        step_nxt = step_r + 1'b1;
        if (step_r == MAC_LAST) state_nxt = S_FILT;
      end
      S_FILT: begin
        ctl.cmd   = CMD_FILT;
        state_nxt = S_REPORT;
      end
      S_EV_RD: begin
        ctl.cmd   = CMD_TBL_RD;
        state_nxt = S_EV_MUL;
      end
      S_EV_MUL: begin
        ctl.cmd   = CMD_EV_MUL;
        state_nxt = S_EV_UPD;
      end
      S_EV_UPD: begin
        ctl.cmd = CMD_EV_UPD;
        if (last_sen) begin
          state_nxt = S_EV_DONE;
        end else begin
          sidx_nxt  = sidx_r + 1'b1;
          state_nxt = S_EV_RD;
        end
      end
      S_EV_DONE: begin
        ctl.cmd   = CMD_EV_DONE;
        state_nxt = S_REPORT;
      end
      S_NS_RD: begin
        ctl.cmd   = CMD_TBL_RD;
        state_nxt = S_NS_M1;
      end
      S_NS_M1: begin
        ctl.cmd   = CMD_NS_M1;
        state_nxt = S_NS_M2;
      end
      S_NS_M2: begin
        ctl.cmd   = CMD_NS_M2;
        state_nxt = S_NS_WR;
      end
      S_NS_WR: begin
        ctl.cmd = CMD_NS_WR;
        if (last_sen) begin
          state_nxt = S_REPORT;
        end else begin
          sidx_nxt  = sidx_r + 1'b1;
          state_nxt = S_NS_RD;
        end
      end
      S_REPORT: begin
        // The result register is reloaded only once the previous word left.
        if (!out_valid_r || out_ready) begin
          ctl.cmd       = CMD_REPORT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sidx_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sidx_r      <= sidx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `KD_ASSERT(a_load_to_disp, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_DISP), "accepted word did not reach dispatch")
  `KD_ASSERT(a_report_valid, clk, rst_n, (ctl.cmd == CMD_REPORT) |=> out_valid_r, "report did not raise out valid")
  `KD_ASSERT(a_report_free, clk, rst_n, (ctl.cmd == CMD_REPORT) |-> (!out_valid_r || out_ready), "result register overwritten")
  `KD_ASSERT(a_mac_end, clk, rst_n, (state_r == S_MAC && step_r == MAC_LAST) |=> (state_r == S_FILT), "filter MAC did not end after four terms")

endmodule

// ----- design/kdrc_dp.sv -----
// Datapath: filters, window tracking, noise floor memory and retard lanes.
module kdrc_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kdrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kdrc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [kdrc_pkg::MODE_W-1:0]      in_mode,
  input  logic [kdrc_pkg::CYL_W-1:0]       in_cylinder,
  input  logic [kdrc_pkg::SEN_W-1:0]       in_sensor,
  input  logic [kdrc_pkg::RAW_W-1:0]       in_raw_sample,
  input  logic [kdrc_pkg::RPM_W-1:0]       in_rpm_value,
  input  kdrc_pkg::ctl_t                   ctl,
  output kdrc_pkg::sts_t                   sts,
  output kdrc_pkg::res_t                   res
);
  import kdrc_pkg::*;

  // Held event word.
  mode_t             mode_r;
  logic [CYL_W-1:0]  cyl_r;
  logic [SEN_W-1:0]  sen_r;
  logic [RAW_W-1:0]  raw_r;
  logic [BIN_W-1:0]  bin_r;

  // Configuration.
  logic [7:0]        thr_r;
  logic [15:0]       alpha_r;
  logic [19:0]       fmin_r;
  logic [RET_W-1:0]  rstep_r, astep_r, rlim_r;

  // Per-sensor state.
  logic signed [SIG_W-1:0] xi0_r [SENSORS];
  logic signed [SIG_W-1:0] xi1_r [SENSORS];
  logic signed [SIG_W-1:0] y0_r  [SENSORS];
  logic signed [SIG_W-1:0] y1_r  [SENSORS];
  logic signed [SIG_W-1:0] lastf_r [SENSORS];
  phase_t                  phase_r [SENSORS];
  logic                    open_valid_r [SENSORS];
  logic [CYL_W-1:0]        open_cyl_r [SENSORS];
  logic [CYL_W-1:0]        pend_r [SENSORS];
  logic [SIG_W-1:0]        wpeak_r [SENSORS];

  // Per-cylinder lanes.
  logic [SIG_W-1:0] cpeak_r [CYLINDERS];
  logic [RET_W-1:0] ret_r [CYLINDERS];
  logic             kflag_r [CYLINDERS];

  logic             any_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MV_W-1:0]  mv_r;
  logic signed [SIG_W-1:0]  filt_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  res_t             res_r;

  // Noise floor memory; entries not yet written read as the reset floor.
  logic [SIG_W-1:0] tbl_mem [TBL_DEPTH];
  logic             tbl_vld_r [TBL_DEPTH];
  logic [SIG_W-1:0] tbl_q_r;
  logic             tbl_qv_r;
  logic [TBL_AW-1:0] tbl_addr;

  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [SEN_W-1:0]   so;
  logic [SIG_W-1:0]   tbl_old, fl_cl, fmin_ext, ns_v;
  logic signed [ACC_W-1:0] ysum, yq, ns_sum;
  logic signed [SIG_W-1:0] ysat;
  logic [SIG_W-1:0]   ymag;
  logic               commit_sel [SENSORS];
  logic [CYL_W-1:0]   ev_c;
  logic               ev_knock;
  logic [RET_W:0]     ev_radd;
  logic [RET_W-1:0]   ev_rnew;
  logic [RET_W-1:0]   bmax [SENSORS];

  assign so       = sensor_of(cyl_r);
  assign tbl_addr = {ctl.sidx, bin_r};
  assign fmin_ext = {4'b0, fmin_r};
  assign tbl_old  = tbl_qv_r ? tbl_q_r : NOISE_INIT;
  assign fl_cl    = (tbl_old < fmin_ext) ? fmin_ext : tbl_old;

  assign sts.mode      = mode_r;
  assign sts.sample_ok = (phase_r[sen_r] == PH_SAMPLING);
  assign res           = res_r;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.cmd)
      CMD_MAC: begin
        case (ctl.step)
          2'd0:    begin mul_a = $signed({5'b0, mv_r});   mul_b = COEF_B0;  end
          2'd1:    begin mul_a = MULA_W'(xi1_r[sen_r]);   mul_b = COEF_B2;  end
          2'd2:    begin mul_a = MULA_W'(y0_r[sen_r]);    mul_b = COEF_NA1; end
          default: begin mul_a = MULA_W'(y1_r[sen_r]);    mul_b = COEF_NA2; end
        endcase
      end
      CMD_EV_MUL: begin
        mul_a = $signed({1'b0, fl_cl});
        mul_b = $signed({10'b0, thr_r});
      end
      CMD_NS_M1: begin
        mul_a = $signed({1'b0, tbl_old});
        mul_b = $signed({1'b0, 17'(17'h10000 - {1'b0, alpha_r})});
      end
      CMD_NS_M2: begin
        mul_a = $signed({1'b0, mag24(lastf_r[ctl.sidx])});
        mul_b = $signed({2'b0, alpha_r});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Filter output: round half up at 2^-16, then saturate to 24 bits.
  always_comb begin
    ysum = acc_r + ACC_W'(prod_r) + 48'sd32768;
    yq   = ysum >>> 16;
    if (yq > 48'sd8388607)       ysat = 24'sh7FFFFF;
    else if (yq < -48'sd8388608) ysat = 24'sh800000;
    else                         ysat = yq[SIG_W-1:0];
    ymag = mag24(ysat);
  end

  always_comb begin
    ns_sum = acc_r + ACC_W'(prod_r);
    ns_v   = ns_sum[SIG_W+15:16];
    if (ns_v < fmin_ext) ns_v = fmin_ext;
  end

  always_comb begin
    for (int s = 0; s < SENSORS; s++) begin
      case (mode_r)
        MODE_CLOSE: commit_sel[s] = (so == SEN_W'(s)) && open_valid_r[s]
                                    && (open_cyl_r[s] == cyl_r);
        MODE_FLUSH: commit_sel[s] = (phase_r[s] == PH_SAMPLING);
        default:    commit_sel[s] = 1'b0;
      endcase
    end
  end

  // Knock test: peak*16 against floor*ratio held in the product register.
  always_comb begin
    ev_c     = pend_r[ctl.sidx];
    ev_knock = {4'b0, cpeak_r[ev_c], 4'b0} > prod_r[31:0];
    ev_radd  = {1'b0, ret_r[ev_c]} + {1'b0, rstep_r};
    if (ev_knock)
      ev_rnew = (ev_radd > {1'b0, rlim_r}) ? rlim_r : ev_radd[RET_W-1:0];
    else
      ev_rnew = (ret_r[ev_c] > astep_r) ? ret_r[ev_c] - astep_r : '0;
  end

  always_comb begin
    for (int s = 0; s < SENSORS; s++) begin
      bmax[s] = '0;
      for (int c = 0; c < CYLINDERS; c++) begin
        if (sensor_of(CYL_W'(c)) == SEN_W'(s) && ret_r[c] > bmax[s]) bmax[s] = ret_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= RST_THRESHOLD_RATIO;
      alpha_r <= RST_NOISE_ALPHA;
      fmin_r  <= RST_NOISE_FLOOR_MIN;
      rstep_r <= RST_RETARD_STEP;
      astep_r <= RST_ADVANCE_STEP;
      rlim_r  <= RST_RETARD_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD_RATIO: thr_r   <= cfg_wdata[7:0];
        CFG_NOISE_ALPHA:     alpha_r <= cfg_wdata[15:0];
        CFG_NOISE_FLOOR_MIN: fmin_r  <= cfg_wdata[19:0];
        CFG_RETARD_STEP:     rstep_r <= cfg_wdata[15:0];
        CFG_ADVANCE_STEP:    astep_r <= cfg_wdata[15:0];
        CFG_RETARD_LIMIT:    rlim_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SENSORS; s++) begin
        xi0_r[s]        <= '0;
        xi1_r[s]        <= '0;
        y0_r[s]         <= '0;
        y1_r[s]         <= '0;
        lastf_r[s]      <= '0;
        phase_r[s]      <= PH_IDLE;
        open_valid_r[s] <= 1'b0;
        open_cyl_r[s]   <= '0;
        pend_r[s]       <= '0;
        wpeak_r[s]      <= '0;
      end
      for (int c = 0; c < CYLINDERS; c++) begin
        cpeak_r[c] <= '0;
        ret_r[c]   <= '0;
        kflag_r[c] <= 1'b0;
      end
      any_r  <= 1'b0;
      cnt_r  <= '0;
      mode_r <= MODE_QUERY;
      filt_r <= '0;
    end else begin
      case (ctl.cmd)
        CMD_LOAD: begin
          mode_r <= mode_t'(in_mode);
          cyl_r  <= in_cylinder;
          sen_r  <= in_sensor;
          raw_r  <= in_raw_sample;
          bin_r  <= rpm_bin(in_rpm_value);
          filt_r <= '0;
          if (mode_t'(in_mode) == MODE_PROCESS) any_r <= 1'b0;
        end
        CMD_SIMPLE: begin
          if (mode_r == MODE_OPEN) begin
            wpeak_r[so]      <= '0;
            open_cyl_r[so]   <= cyl_r;
            open_valid_r[so] <= 1'b1;
            phase_r[so]      <= PH_SAMPLING;
          end
          for (int s = 0; s < SENSORS; s++) begin
            if (commit_sel[s]) begin
              if (open_valid_r[s]) begin
                cpeak_r[open_cyl_r[s]] <= wpeak_r[s];
                pend_r[s]              <= open_cyl_r[s];
                phase_r[s]             <= PH_PROCESS;
              end else begin
                phase_r[s] <= PH_IDLE;
                wpeak_r[s] <= '0;
              end
              open_valid_r[s] <= 1'b0;
            end
          end
        end
        CMD_MV: mv_r <= MV_W'(({12'b0, raw_r} * 24'd3300 + 24'd8) >> 4);
        CMD_MAC: begin
          prod_r <= mul_p;
          acc_r  <= (ctl.step == '0) ? '0 : acc_r + ACC_W'(prod_r);
        end
        CMD_FILT: begin
          xi1_r[sen_r]   <= xi0_r[sen_r];
          xi0_r[sen_r]   <= $signed({4'b0, mv_r});
          y1_r[sen_r]    <= y0_r[sen_r];
          y0_r[sen_r]    <= ysat;
          lastf_r[sen_r] <= ysat;
          filt_r         <= ysat;
          if (ymag > wpeak_r[sen_r]) wpeak_r[sen_r] <= ymag;
        end
        CMD_EV_MUL, CMD_NS_M1: prod_r <= mul_p;
        CMD_EV_UPD: begin
          if (phase_r[ctl.sidx] == PH_PROCESS) begin
            kflag_r[ev_c]      <= ev_knock;
            ret_r[ev_c]        <= ev_rnew;
            phase_r[ctl.sidx]  <= PH_IDLE;
            if (ev_knock) any_r <= 1'b1;
          end
        end
        CMD_EV_DONE: if (any_r && cnt_r != '1) cnt_r <= cnt_r + 1'b1;
        CMD_NS_M2: begin
          acc_r  <= ACC_W'(prod_r) + 48'sd32768;
          prod_r <= mul_p;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_NS_WR) tbl_mem[tbl_addr] <= ns_v;
    if (ctl.cmd == CMD_TBL_RD) tbl_q_r <= tbl_mem[tbl_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL_DEPTH; i++) tbl_vld_r[i] <= 1'b0;
      tbl_qv_r <= 1'b0;
    end else begin
      if (ctl.cmd == CMD_NS_WR) tbl_vld_r[tbl_addr] <= 1'b1;
      if (ctl.cmd == CMD_TBL_RD) tbl_qv_r <= tbl_vld_r[tbl_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_REPORT) begin
      res_r.cylinder_retard  <= ret_r[cyl_r];
      res_r.cylinder_knocked <= kflag_r[cyl_r];
      res_r.bank1_retard     <= bmax[0];
      res_r.bank2_retard     <= bmax[SENSORS-1];
      res_r.knock_active     <= any_r;
      res_r.event_total      <= cnt_r;
      res_r.filtered_out     <= filt_r;
    end
  end

endmodule

// ----- design/knock_detect_retard_control.sv -----
// Knock detection and retard control, top level.
// Open, close, flush and query go from accept through dispatch straight to report;
// a sample adds four passes through the shared filter multiplier; process and noise
// update step through two sensors, with a registered floor memory read for each.
// One event at a time; the next word is taken the cycle after its result is loaded.
// Synchronous active-low reset restores control, configuration, filters and floors.
module knock_detect_retard_control (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kdrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kdrc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  kdrc_in_if.sink                          in_ch,
  kdrc_out_if.source                       out_ch
);
  import kdrc_pkg::*;

  ctl_t ctl;
  sts_t sts;
  res_t res;

  kdrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  kdrc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_mode       (in_ch.mode),
    .in_cylinder   (in_ch.cylinder),
    .in_sensor     (in_ch.sensor),
    .in_raw_sample (in_ch.raw_sample),
    .in_rpm_value  (in_ch.rpm_value),
    .ctl           (ctl),
    .sts           (sts),
    .res           (res)
  );

  assign out_ch.cylinder_retard  = res.cylinder_retard;
  assign out_ch.cylinder_knocked = res.cylinder_knocked;
  assign out_ch.bank1_retard     = res.bank1_retard;
  assign out_ch.bank2_retard     = res.bank2_retard;
  assign out_ch.knock_active     = res.knock_active;
  assign out_ch.event_total      = res.event_total;
  assign out_ch.filtered_out     = res.filtered_out;

endmodule
